FILE: src/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/i2cm_pkg.sv
// Shared types and constants for the I2C master register transfer block.
// No dependencies.
`timescale 1ns / 1ps
package i2cm_pkg;

  localparam int unsigned BUF_DEPTH = 16;
  localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);
  localparam int unsigned READ_MAX  = 16;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic       sda_in;
    logic [7:0] device_addr;
    logic [7:0] register_addr;
    logic [4:0] transfer_length;
    logic [3:0] load_index;
    logic [7:0] load_byte;
  } in_beat_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic       success;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [3:0] read_index;
  } out_beat_t;

endpackage

FILE: src/i2c_master_register_transfer.sv
// I2C master register transfer: top level, one pin step per input beat.
// Depends on i2cm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
//  channel | ports                          | direction | carries
//  --------+--------------------------------+-----------+------------------------------
//  input   | in_valid, in_ready, in_data    | into      | one bus tick / load / start
//  result  | out_valid, out_ready, out_data | out of    | pin levels and status per tick
//
// Every accepted input beat yields exactly one result beat, registered and presented in the next cycle.
// The block takes one beat per cycle; the single output register sets the pace,
// so in_ready drops only while a result is held and out_ready is low.
// Reset (rst_n low, synchronous) returns the sequencer to idle with SCL high and
// SDA driven high. The write buffer has no reset; entries read back what was loaded.
// A stalled result holds the whole block: no state moves until the beat is taken.
module i2c_master_register_transfer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2cm_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output i2cm_pkg::out_beat_t out_data
);

  // Bus sequencer phases; each phase is one pin operation or one idle tick.
  typedef enum logic [4:0] {
    PH_IDLE, PH_START_SDA, PH_START_SCL,
    PH_WB_SDA, PH_WB_SCLH, PH_WB_SCLL, PH_WB_REL, PH_WB_ACKH, PH_WB_SAMPLE,
    PH_WB_DRV, PH_WB_ACKL, PH_WB_DELAY,
    PH_RB_REL, PH_RB_SCLH, PH_RB_SCLL, PH_RB_SETACK, PH_RB_DRV, PH_RB_ACKH,
    PH_RB_ACKL, PH_RB_DELAY,
    PH_MID_SCLH, PH_MID_SDAH, PH_MID_DELAY,
    PH_END_SDAL, PH_STOP_SCLH, PH_STOP_SDAH
  } phase_t;

  // Which byte of the transaction is on the wire
  typedef enum logic [1:0] {ST_ADDR, ST_REG, ST_DATA, ST_RADDR} stage_t;

  phase_t     phase_r,    phase_nxt;
  stage_t     stage_r,    stage_nxt;
  logic [3:0] bit_cnt_r,  bit_cnt_nxt;
  logic [4:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0] shift_r,    shift_nxt;
  logic [7:0] addr_r,     addr_nxt;
  logic [7:0] reg_r,      reg_nxt;
  logic [4:0] len_r,      len_nxt;
  logic       is_read_r,  is_read_nxt;
  logic       ok_r,       ok_nxt;
  logic       scl_r,      scl_nxt;
  logic       sda_r,      sda_nxt;
  logic       drv_r,      drv_nxt;

  logic                out_valid_r, out_valid_nxt;
  i2cm_pkg::out_beat_t out_data_r,  res_nxt;

  logic [7:0] wbuf_r [i2cm_pkg::BUF_DEPTH];

  logic                       in_acc;
  logic                       load_hit;
  logic                       start_req;
  logic [i2cm_pkg::BUF_AW-1:0] next_idx;
  logic [7:0]                 buf_first;
  logic [7:0]                 buf_next;
  logic [5:0]                 bc_inc;
  logic [4:0]                 len_sat;

  assign in_acc    = in_valid && in_ready;
  assign load_hit  = (in_data.req_type == i2cm_pkg::REQ_LOAD);
  assign start_req = (phase_r == PH_IDLE) &&
                     ((in_data.req_type == i2cm_pkg::REQ_WRITE) ||
                      (in_data.req_type == i2cm_pkg::REQ_READ));

  // Buffer reads see a load made on the same tick.
  assign next_idx  = byte_cnt_r[i2cm_pkg::BUF_AW-1:0] + 1'b1;
  assign buf_first = (load_hit && in_data.load_index == '0) ? in_data.load_byte : wbuf_r[0];
  assign buf_next  = (load_hit && in_data.load_index == next_idx) ?
                     in_data.load_byte : wbuf_r[next_idx];

  assign bc_inc = {1'b0, byte_cnt_r} + 6'd1;

  // Clamp the requested length: reads to 1..READ_MAX, writes to 0..BUF_DEPTH.
  always_comb begin
    len_sat = in_data.transfer_length;
    if (in_data.req_type == i2cm_pkg::REQ_READ) begin
      if (len_sat == '0) len_sat = 5'd1;
      if (len_sat > 5'(i2cm_pkg::READ_MAX)) len_sat = 5'(i2cm_pkg::READ_MAX);
    end else if (len_sat > 5'(i2cm_pkg::BUF_DEPTH)) begin
      len_sat = 5'(i2cm_pkg::BUF_DEPTH);
    end
  end

  // One tick of the sequencer: latch a start, then perform the phase's pin step.
  always_comb begin
    phase_nxt    = phase_r;
    stage_nxt    = stage_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    shift_nxt    = shift_r;
    addr_nxt     = addr_r;
    reg_nxt      = reg_r;
    len_nxt      = len_r;
    is_read_nxt  = is_read_r;
    ok_nxt       = ok_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    drv_nxt      = drv_r;
    res_nxt      = '0;

    if (start_req) begin
      is_read_nxt  = (in_data.req_type == i2cm_pkg::REQ_READ);
      addr_nxt     = in_data.device_addr & 8'hFE;
      reg_nxt      = in_data.register_addr;
      len_nxt      = len_sat;
      stage_nxt    = ST_ADDR;
      ok_nxt       = 1'b1;
      byte_cnt_nxt = '0;
      phase_nxt    = PH_START_SDA;
    end

    if (phase_nxt != PH_IDLE) begin
      res_nxt.busy_res = 1'b1;
      case (phase_nxt)
        PH_START_SDA: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_START_SCL;
        end
        PH_START_SCL: begin
          scl_nxt     = 1'b0;
          shift_nxt   = (stage_nxt == ST_RADDR) ? (addr_nxt | 8'h01) : addr_nxt;
          bit_cnt_nxt = '0;
          phase_nxt   = PH_WB_SDA;
        end
        PH_WB_SDA: begin
          sda_nxt   = shift_r[7];
          phase_nxt = PH_WB_SCLH;
        end
        PH_WB_SCLH: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_WB_SCLL;
        end
        PH_WB_SCLL: begin
          shift_nxt   = {shift_r[6:0], 1'b0};
          scl_nxt     = 1'b0;
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          phase_nxt   = (bit_cnt_nxt >= 4'd8) ? PH_WB_REL : PH_WB_SDA;
        end
        PH_WB_REL: begin
          drv_nxt   = 1'b0;
          phase_nxt = PH_WB_ACKH;
        end
        PH_WB_ACKH: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_WB_SAMPLE;
        end
        PH_WB_SAMPLE: begin
          ok_nxt    = !in_data.sda_in;
          sda_nxt   = in_data.sda_in;
          phase_nxt = PH_WB_DRV;
        end
        PH_WB_DRV: begin
          drv_nxt   = 1'b1;
          phase_nxt = PH_WB_ACKL;
        end
        PH_WB_ACKL: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_WB_DELAY;
        end
        PH_WB_DELAY: begin
          if (!ok_r) begin
            phase_nxt = PH_END_SDAL;
          end else begin
            case (stage_r)
              ST_ADDR: begin
                stage_nxt   = ST_REG;
                shift_nxt   = reg_r;
                bit_cnt_nxt = '0;
                phase_nxt   = PH_WB_SDA;
              end
              ST_REG: begin
                if (is_read_r) begin
                  phase_nxt = PH_MID_SCLH;
                end else if (len_r == '0) begin
                  phase_nxt = PH_STOP_SCLH;
                end else begin
                  stage_nxt    = ST_DATA;
                  byte_cnt_nxt = '0;
                  shift_nxt    = buf_first;
                  bit_cnt_nxt  = '0;
                  phase_nxt    = PH_WB_SDA;
                end
              end
              ST_DATA: begin
                byte_cnt_nxt = bc_inc[4:0];
                if (bc_inc >= {1'b0, len_r}) begin
                  phase_nxt = PH_STOP_SCLH;
                end else begin
                  shift_nxt   = buf_next;
                  bit_cnt_nxt = '0;
                  phase_nxt   = PH_WB_SDA;
                end
              end
              default: begin
                byte_cnt_nxt = '0;
                phase_nxt    = PH_RB_REL;
              end
            endcase
          end
        end
        PH_MID_SCLH: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_MID_SDAH;
        end
        PH_MID_SDAH: begin
          sda_nxt   = 1'b1;
          phase_nxt = PH_MID_DELAY;
        end
        PH_MID_DELAY: begin
          stage_nxt = ST_RADDR;
          phase_nxt = PH_START_SDA;
        end
        PH_RB_REL: begin
          drv_nxt     = 1'b0;
          bit_cnt_nxt = '0;
          phase_nxt   = PH_RB_SCLH;
        end
        PH_RB_SCLH: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_RB_SCLL;
        end
        PH_RB_SCLL: begin
          shift_nxt   = {shift_r[6:0], in_data.sda_in};
          scl_nxt     = 1'b0;
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          phase_nxt   = (bit_cnt_nxt >= 4'd8) ? PH_RB_SETACK : PH_RB_SCLH;
        end
        PH_RB_SETACK: begin
          // Not-acknowledge on the last byte, acknowledge otherwise
          sda_nxt   = (bc_inc >= {1'b0, len_r});
          phase_nxt = PH_RB_DRV;
        end
        PH_RB_DRV: begin
          drv_nxt   = 1'b1;
          phase_nxt = PH_RB_ACKH;
        end
        PH_RB_ACKH: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_RB_ACKL;
        end
        PH_RB_ACKL: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_RB_DELAY;
        end
        PH_RB_DELAY: begin
          res_nxt.read_valid = 1'b1;
          res_nxt.read_byte  = shift_r;
          res_nxt.read_index = byte_cnt_r[3:0];
          byte_cnt_nxt       = bc_inc[4:0];
          phase_nxt          = (bc_inc >= {1'b0, len_r}) ? PH_END_SDAL : PH_RB_REL;
        end
        PH_END_SDAL: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_STOP_SCLH;
        end
        PH_STOP_SCLH: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_STOP_SDAH;
        end
        PH_STOP_SDAH: begin
          sda_nxt          = 1'b1;
          res_nxt.done_res = 1'b1;
          res_nxt.success  = ok_r;
          phase_nxt        = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    res_nxt.scl_level        = scl_nxt;
    res_nxt.sda_level        = sda_nxt;
    res_nxt.sda_drive_enable = drv_nxt;
  end

  // Output register: accept a new beat whenever the held result is gone or leaving.
  assign in_ready      = !out_valid_r || out_ready;
  assign out_valid_nxt = in_acc || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      stage_r     <= ST_ADDR;
      bit_cnt_r   <= '0;
      byte_cnt_r  <= '0;
      shift_r     <= '0;
      addr_r      <= '0;
      reg_r       <= '0;
      len_r       <= '0;
      is_read_r   <= 1'b0;
      ok_r        <= 1'b1;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      drv_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r    <= phase_nxt;
        stage_r    <= stage_nxt;
        bit_cnt_r  <= bit_cnt_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        shift_r    <= shift_nxt;
        addr_r     <= addr_nxt;
        reg_r      <= reg_nxt;
        len_r      <= len_nxt;
        is_read_r  <= is_read_nxt;
        ok_r       <= ok_nxt;
        scl_r      <= scl_nxt;
        sda_r      <= sda_nxt;
        drv_r      <= drv_nxt;
      end
    end
  end

  // Payload storage: result register and write buffer carry no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res_nxt;
      if (load_hit) begin
        wbuf_r[in_data.load_index] <= in_data.load_byte;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A finish beat always belongs to a running transaction.
  `ASSERT_IMP(a_done_busy, clk, rst_n, out_valid && out_data.done_res, out_data.busy_res)
  // Success is only reported together with done.
  `ASSERT_IMP(a_succ_done, clk, rst_n, out_valid && !out_data.done_res, !out_data.success)
  // A start accepted while idle shows up as a busy result on the next beat.
  `ASSERT_NXT(a_start_busy, clk, rst_n, in_acc && start_req, out_valid && out_data.busy_res)
  // A received byte is presented only after the master retook SDA for the ack.
  `ASSERT_IMP(a_rd_drv, clk, rst_n, out_valid && out_data.read_valid,
              out_data.sda_drive_enable && is_read_r)

endmodule
